FILE: design/bst_pkg.sv
// Package for the bencode stream tokenizer.
// Holds parse mode codes, token and error codes, character codes and the
// stack command and status types; no dependencies.
package bst_pkg;

  localparam logic [2:0] MODE_LEAD       = 3'd0;
  localparam logic [2:0] MODE_INT_START  = 3'd1;
  localparam logic [2:0] MODE_INT_DIGITS = 3'd2;
  localparam logic [2:0] MODE_STRLEN     = 3'd3;
  localparam logic [2:0] MODE_STRBODY    = 3'd4;

  localparam logic [2:0] TOK_INT   = 3'd0;
  localparam logic [2:0] TOK_LEN   = 3'd1;
  localparam logic [2:0] TOK_BYTE  = 3'd2;
  localparam logic [2:0] TOK_LIST  = 3'd3;
  localparam logic [2:0] TOK_DICT  = 3'd4;
  localparam logic [2:0] TOK_CLOSE = 3'd5;
  localparam logic [2:0] TOK_ERR   = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEAD     = 3'd1;
  localparam logic [2:0] ERR_DIGIT    = 3'd2;
  localparam logic [2:0] ERR_INT_FORM = 3'd3;
  localparam logic [2:0] ERR_DEEP     = 3'd4;
  localparam logic [2:0] ERR_STRAY    = 3'd5;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // kind: 1 for a dictionary; key: 1 when a key is expected next
  typedef struct packed {
    logic kind;
    logic key;
  } stk_entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic flip;
    logic push_dict;
  } stk_cmd_t;

  typedef struct packed {
    stk_entry_t top;
    stk_entry_t below;
  } stk_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

FILE: design/bst_stack.sv
// Container stack of the bencode stream tokenizer: depth counter, the top two
// levels in registers and the deeper levels in a small memory.
// Depends on bst_pkg.
module bst_stack #(
  parameter int MAX_DEPTH = 16,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bst_pkg::stk_cmd_t  cmd,
  output logic [DW-1:0]      depth,
  output bst_pkg::stk_stat_t stat
);
  import bst_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  stk_entry_t    mem [MAX_DEPTH];
  logic [DW-1:0] depth_r, depth_nxt;
  stk_entry_t    top_r, top_nxt;
  stk_entry_t    below_r;
  logic [DW-1:0] wr_pos, rd_pos;
  logic [AW-1:0] wr_idx, rd_idx;
  logic          do_push, do_pop;

  assign do_push = cmd.push && !cmd.clear;
  assign do_pop  = cmd.pop && !cmd.clear;
  assign wr_pos  = depth_r - DW'(1);
  assign rd_pos  = depth_r - DW'(3);
  assign wr_idx  = wr_pos[AW-1:0];
  assign rd_idx  = rd_pos[AW-1:0];

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (cmd.clear) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt     = depth_r + DW'(1);
      top_nxt.kind  = cmd.push_dict;
      top_nxt.key   = cmd.push_dict;
    end else if (cmd.pop) begin
      depth_nxt   = depth_r - DW'(1);
      top_nxt     = below_r;
      top_nxt.key = below_r.key ^ cmd.flip;
    end else if (cmd.flip) begin
      top_nxt.key = ~top_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_push && (depth_r != '0)) begin
      mem[wr_idx] <= top_r;
    end
    if (do_push) begin
      below_r <= top_r;
    end else if (do_pop) begin
      below_r <= mem[rd_idx];
    end
  end

  assign depth      = depth_r;
  assign stat.top   = top_r;
  assign stat.below = below_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("stack depth above limit");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> depth_r < DW'(MAX_DEPTH))
    else $error("push on full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> depth_r != '0)
    else $error("pop on empty stack");

endmodule

FILE: design/bencode_stream_tokenizer_unit.sv
// Bencode stream tokenizer: one byte per request in, at most one token out.
// Top level; depends on bst_pkg and bst_stack.
//
// Takes one byte of a bencoded stream per request and returns zero or one
// token: integer value, string length, each string byte (last one marked),
// list open, dict open, close, or an error, after which parsing restarts at
// top level. Each byte makes a single pass between an input register and a
// result register, so a new byte is accepted every cycle while the result
// side keeps up. The result register stalls the input only when it holds a
// token not yet taken. Containers nest up to MAX_DEPTH levels; no clearing
// pass after reset.
module bencode_stream_tokenizer_unit #(
  parameter int MAX_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_token_kind,
  output logic signed [31:0] out_number_value,
  output logic [7:0]         out_string_byte,
  output logic [4:0]         out_nest_depth,
  output logic               out_in_key,
  output logic               out_end_of_string,
  output logic               out_value_done,
  output logic [2:0]         out_error_code
);
  import bst_pkg::*;

  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int DXW = DW + 5;

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               adv;

  logic [2:0]         mode_r, mode_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               dseen_r, dseen_nxt;
  logic [30:0]        rem_r, rem_nxt;

  stk_cmd_t           cmd_c, cmd;
  stk_stat_t          stat;
  logic [DW-1:0]      depth_q, depth_dec;
  logic [DXW-1:0]     dep_ext, dec_ext;
  logic [4:0]         cur5, dec5;

  logic [7:0]         b, dv;
  logic               dig, top_dict, key_now, pop_key, fin_done;
  logic [31:0]        acc_mac;
  logic [30:0]        rem_dec;

  logic               emit, err;
  logic [2:0]         tk, ecode;
  logic signed [31:0] nv;
  logic [7:0]         sb;
  logic [4:0]         nd;
  logic               ky, eos, done;

  logic               out_valid_r;
  logic [2:0]         tk_r, ecode_r;
  logic signed [31:0] nv_r;
  logic [7:0]         sb_r;
  logic [4:0]         nd_r;
  logic               ky_r, eos_r, done_r;

  bst_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .depth (depth_q),
    .stat  (stat)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  assign b         = s1_byte_r;
  assign dig       = is_digit(b);
  assign dv        = b - CH_ZERO;
  assign acc_mac   = (acc_r << 3) + (acc_r << 1) + 32'(dv[3:0]);
  assign rem_dec   = (rem_r != '0) ? (rem_r - 31'd1) : rem_r;
  assign depth_dec = depth_q - DW'(1);
  assign dep_ext   = DXW'(depth_q);
  assign dec_ext   = DXW'(depth_dec);
  assign cur5      = dep_ext[4:0];
  assign dec5      = dec_ext[4:0];
  assign top_dict  = (depth_q != '0) && stat.top.kind;
  assign key_now   = top_dict && stat.top.key;
  assign fin_done  = (depth_q == '0);
  assign pop_key   = (depth_dec != '0) && stat.below.kind && stat.below.key;

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    dseen_nxt = dseen_r;
    rem_nxt   = rem_r;
    cmd_c     = '0;
    emit      = 1'b0;
    err       = 1'b0;
    tk        = TOK_INT;
    ecode     = ERR_NONE;
    nv        = '0;
    sb        = '0;
    nd        = cur5;
    ky        = key_now;
    eos       = 1'b0;
    done      = 1'b0;
    unique case (mode_r)
      MODE_INT_START: begin
        if (b == CH_MINUS) begin
          neg_nxt  = 1'b1;
          mode_nxt = MODE_INT_DIGITS;
        end else if (b == CH_E) begin
          err   = 1'b1;
          ecode = ERR_INT_FORM;
        end else if (!dig) begin
          err   = 1'b1;
          ecode = ERR_DIGIT;
        end else begin
          acc_nxt   = 32'(dv[3:0]);
          dseen_nxt = 1'b1;
          mode_nxt  = MODE_INT_DIGITS;
        end
      end
      MODE_INT_DIGITS: begin
        if (b == CH_E) begin
          if (!dseen_r || (neg_r && (acc_r == '0))) begin
            err   = 1'b1;
            ecode = ERR_INT_FORM;
          end else begin
            emit       = 1'b1;
            tk         = TOK_INT;
            nv         = neg_r ? $signed(32'd0 - acc_r) : $signed(acc_r);
            done       = fin_done;
            cmd_c.flip = top_dict;
            mode_nxt   = MODE_LEAD;
            acc_nxt    = '0;
            neg_nxt    = 1'b0;
            dseen_nxt  = 1'b0;
          end
        end else if (!dig) begin
          err   = 1'b1;
          ecode = ERR_DIGIT;
        end else begin
          acc_nxt   = acc_mac;
          dseen_nxt = 1'b1;
        end
      end
      MODE_STRLEN: begin
        if (dig) begin
          acc_nxt = acc_mac;
        end else if (b != CH_COLON) begin
          err   = 1'b1;
          ecode = ERR_DIGIT;
        end else begin
          rem_nxt = acc_r[30:0];
          emit    = 1'b1;
          tk      = TOK_LEN;
          nv      = $signed({1'b0, acc_r[30:0]});
          if (acc_r[30:0] == '0) begin
            done       = fin_done;
            cmd_c.flip = top_dict;
            mode_nxt   = MODE_LEAD;
          end else begin
            mode_nxt = MODE_STRBODY;
          end
          acc_nxt   = '0;
          dseen_nxt = 1'b0;
        end
      end
      MODE_STRBODY: begin
        rem_nxt = rem_dec;
        emit    = 1'b1;
        tk      = TOK_BYTE;
        sb      = b;
        if (rem_dec == '0) begin
          eos        = 1'b1;
          done       = fin_done;
          cmd_c.flip = top_dict;
          mode_nxt   = MODE_LEAD;
        end
      end
      default: begin
        mode_nxt = MODE_LEAD;
        if (b == CH_E) begin
          if (depth_q == '0) begin
            err   = 1'b1;
            ecode = ERR_STRAY;
          end else if (top_dict && !stat.top.key) begin
            err   = 1'b1;
            ecode = ERR_STRAY;
          end else begin
            emit       = 1'b1;
            tk         = TOK_CLOSE;
            cmd_c.pop  = 1'b1;
            nd         = dec5;
            ky         = pop_key;
            done       = (depth_dec == '0);
            cmd_c.flip = (depth_dec != '0) && stat.below.kind;
          end
        end else if (key_now && !dig) begin
          err   = 1'b1;
          ecode = ERR_LEAD;
        end else if (dig) begin
          acc_nxt   = 32'(dv[3:0]);
          dseen_nxt = 1'b1;
          mode_nxt  = MODE_STRLEN;
        end else if (b == CH_I) begin
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          dseen_nxt = 1'b0;
          mode_nxt  = MODE_INT_START;
        end else if ((b == CH_L) || (b == CH_D)) begin
          if (depth_q >= DW'(MAX_DEPTH)) begin
            err   = 1'b1;
            ecode = ERR_DEEP;
          end else begin
            emit            = 1'b1;
            tk              = (b == CH_D) ? TOK_DICT : TOK_LIST;
            cmd_c.push      = 1'b1;
            cmd_c.push_dict = (b == CH_D);
          end
        end else begin
          err   = 1'b1;
          ecode = ERR_LEAD;
        end
      end
    endcase
    if (err) begin
      emit        = 1'b1;
      tk          = TOK_ERR;
      nv          = '0;
      sb          = '0;
      nd          = cur5;
      ky          = key_now;
      eos         = 1'b0;
      done        = 1'b0;
      mode_nxt    = MODE_LEAD;
      acc_nxt     = '0;
      neg_nxt     = 1'b0;
      dseen_nxt   = 1'b0;
      rem_nxt     = '0;
      cmd_c       = '0;
      cmd_c.clear = 1'b1;
    end
  end

  assign cmd = adv ? cmd_c : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LEAD;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      dseen_r <= 1'b0;
      rem_r   <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      dseen_r <= dseen_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      tk_r    <= tk;
      nv_r    <= nv;
      sb_r    <= sb;
      nd_r    <= nd;
      ky_r    <= ky;
      eos_r   <= eos;
      done_r  <= done;
      ecode_r <= ecode;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_kind    = tk_r;
  assign out_number_value  = nv_r;
  assign out_string_byte   = sb_r;
  assign out_nest_depth    = nd_r;
  assign out_in_key        = ky_r;
  assign out_end_of_string = eos_r;
  assign out_value_done    = done_r;
  assign out_error_code    = ecode_r;

  a_err_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && err) |=> (depth_q == '0) && (mode_r == MODE_LEAD))
    else $error("error did not return parser to top level");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STRBODY) |-> (rem_r != '0))
    else $error("string body with no bytes left");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

FILE: tb/bencode_stream_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for bencode_stream_tokenizer_unit: byte stream in, tokens out, with a
// token predictor and scoreboard, directed and random streams, and idles on both sides.
// Depends on bst_pkg and the design files.
module bencode_stream_tokenizer_unit_tb;
  import bst_pkg::*;

  localparam int MAX_NEST = 16;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] number;
    logic [7:0]  sbyte;
    logic [4:0]  depth;
    logic        key;
    logic        eos;
    logic        done;
    logic [2:0]  err;
  } token_t;

  class token_board;
    token_t      tokens_due[$];
    int          errors;
    logic [2:0]  mode;
    logic [31:0] acc;
    logic        neg;
    logic        seen;
    logic [30:0] remaining;
    int          depth;
    bit          kind_stk[MAX_NEST];
    bit          key_stk[MAX_NEST];

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_LEAD;
      acc = '0;
      neg = 1'b0;
      seen = 1'b0;
      remaining = '0;
      depth = 0;
    endfunction

    function bit at_top();
      return mode == MODE_LEAD && depth == 0;
    endfunction

    function bit numeral(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function bit top_dict();
      if (depth == 0) return 1'b0;
      return kind_stk[depth-1];
    endfunction

    function bit key_side();
      if (!top_dict()) return 1'b0;
      return key_stk[depth-1];
    endfunction

    function bit close_value();
      if (depth == 0) return 1'b1;
      if (top_dict()) key_stk[depth-1] = !key_stk[depth-1];
      return 1'b0;
    endfunction

    function void emit(logic [2:0] kind, logic [31:0] number, logic [7:0] sbyte,
                       bit key, bit eos, bit done, logic [2:0] err);
      token_t t;
      t.kind = kind;
      t.number = number;
      t.sbyte = sbyte;
      t.depth = depth[4:0];
      t.key = key;
      t.eos = eos;
      t.done = done;
      t.err = err;
      tokens_due.push_back(t);
    endfunction

    function void fail(logic [2:0] code);
      emit(TOK_ERR, '0, '0, key_side(), 1'b0, 1'b0, code);
      clear();
    endfunction

    function void lead_byte(logic [7:0] b);
      bit key;
      bit done;
      if (b == CH_E) begin
        if (depth == 0 || (top_dict() && !key_stk[depth-1])) fail(ERR_STRAY);
        else begin
          depth--;
          key = key_side();
          done = close_value();
          emit(TOK_CLOSE, '0, '0, key, 1'b0, done, ERR_NONE);
        end
      end else if (key_side() && !numeral(b)) fail(ERR_LEAD);
      else if (numeral(b)) begin
        acc = 32'(b - CH_ZERO);
        seen = 1'b1;
        mode = MODE_STRLEN;
      end else if (b == CH_I) begin
        acc = '0;
        neg = 1'b0;
        seen = 1'b0;
        mode = MODE_INT_START;
      end else if (b == CH_L || b == CH_D) begin
        if (depth >= MAX_NEST) fail(ERR_DEEP);
        else begin
          emit(b == CH_L ? TOK_LIST : TOK_DICT, '0, '0, key_side(), 1'b0, 1'b0, ERR_NONE);
          kind_stk[depth] = (b == CH_D);
          key_stk[depth] = (b == CH_D);
          depth++;
        end
      end else fail(ERR_LEAD);
    endfunction

    function void note_byte(logic [7:0] b);
      bit key;
      bit done;
      case (mode)
        MODE_INT_START: begin
          if (b == CH_MINUS) begin
            neg = 1'b1;
            mode = MODE_INT_DIGITS;
          end else if (b == CH_E) fail(ERR_INT_FORM);
          else if (!numeral(b)) fail(ERR_DIGIT);
          else begin
            acc = 32'(b - CH_ZERO);
            seen = 1'b1;
            mode = MODE_INT_DIGITS;
          end
        end
        MODE_INT_DIGITS: begin
          if (b == CH_E) begin
            if (!seen || (neg && acc == 0)) fail(ERR_INT_FORM);
            else begin
              key = key_side();
              done = close_value();
              emit(TOK_INT, neg ? 32'd0 - acc : acc, '0, key, 1'b0, done, ERR_NONE);
              mode = MODE_LEAD;
              acc = '0;
              neg = 1'b0;
              seen = 1'b0;
            end
          end else if (!numeral(b)) fail(ERR_DIGIT);
          else begin
            acc = acc * 32'd10 + 32'(b - CH_ZERO);
            seen = 1'b1;
          end
        end
        MODE_STRLEN: begin
          if (numeral(b)) acc = acc * 32'd10 + 32'(b - CH_ZERO);
          else if (b != CH_COLON) fail(ERR_DIGIT);
          else begin
            remaining = acc[30:0];
            key = key_side();
            done = 1'b0;
            if (remaining == 0) begin
              done = close_value();
              mode = MODE_LEAD;
            end else mode = MODE_STRBODY;
            emit(TOK_LEN, {1'b0, remaining}, '0, key, 1'b0, done, ERR_NONE);
            acc = '0;
            seen = 1'b0;
          end
        end
        MODE_STRBODY: begin
          key = key_side();
          done = 1'b0;
          if (remaining > 0) remaining--;
          if (remaining == 0) begin
            done = close_value();
            mode = MODE_LEAD;
          end
          emit(TOK_BYTE, '0, b, key, remaining == 0, done, ERR_NONE);
        end
        default: lead_byte(b);
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_token(logic [2:0] k, logic [31:0] num, logic [7:0] sb,
                              logic [4:0] dep, logic ky, logic eos, logic dn,
                              logic [2:0] er);
      token_t t;
      if (tokens_due.size() == 0) begin
        $error("token kind %0d arrived with nothing pending", k);
        errors++;
        return;
      end
      t = tokens_due.pop_front();
      cmp_field("token_kind", t.kind, k);
      cmp_field("number_value", t.number, num);
      cmp_field("string_byte", t.sbyte, sb);
      cmp_field("nest_depth", t.depth, dep);
      cmp_field("in_key", t.key, ky);
      cmp_field("end_of_string", t.eos, eos);
      cmp_field("value_done", t.done, dn);
      cmp_field("error_code", t.err, er);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_token_kind;
  logic signed [31:0] out_number_value;
  logic [7:0]         out_string_byte;
  logic [4:0]         out_nest_depth;
  logic               out_in_key;
  logic               out_end_of_string;
  logic               out_value_done;
  logic [2:0]         out_error_code;

  token_board board;
  logic [7:0] burst[$];
  int         sent = 0;
  int         tx_rate = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  bencode_stream_tokenizer_unit #(.MAX_DEPTH(MAX_NEST)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_number_value(out_number_value),
    .out_string_byte(out_string_byte),
    .out_nest_depth(out_nest_depth),
    .out_in_key(out_in_key),
    .out_end_of_string(out_end_of_string),
    .out_value_done(out_value_done),
    .out_error_code(out_error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  function automatic void push_decimal(longint unsigned v);
    push_text($sformatf("%0d", v));
  endfunction

  function automatic void gen_string();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    push_decimal(len);
    burst.push_back(CH_COLON);
    repeat (len) burst.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_int();
    longint unsigned mag;
    burst.push_back(CH_I);
    if ($urandom_range(0, 2) == 0) burst.push_back(CH_MINUS);
    if ($urandom_range(0, 5) == 0) burst.push_back(CH_ZERO);
    if ($urandom_range(0, 3) == 0) mag = {$urandom, $urandom} % 64'd99999999999;
    else mag = $urandom_range(0, 999);
    push_decimal(mag);
    burst.push_back(CH_E);
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    case ($urandom_range(0, lvl >= 4 ? 1 : 3))
      0: gen_int();
      1: gen_string();
      2: begin
        burst.push_back(CH_L);
        n = $urandom_range(0, 3);
        repeat (n) gen_value(lvl + 1);
        burst.push_back(CH_E);
      end
      default: begin
        burst.push_back(CH_D);
        n = $urandom_range(0, 3);
        repeat (n) begin
          gen_string();
          gen_value(lvl + 1);
        end
        burst.push_back(CH_E);
      end
    endcase
  endfunction

  function automatic void gen_special();
    case ($urandom_range(0, 13))
      0: push_text("i-e");
      1: push_text("i4294967295e");
      2: push_text("i-2147483648e");
      3: push_text("i2147483647e");
      4: push_text("i-4294967296e");
      5: push_text("i0007e");
      6: push_text("i--");
      7: push_text("3x");
      8: push_text("4294967297:z");
      9: push_text("d0:lee");
      10: push_text("di1ee");
      11: push_text("2147483649:q");
      12: begin
        repeat (MAX_NEST) burst.push_back(CH_L);
        push_text("i5e");
        repeat (MAX_NEST) burst.push_back(CH_E);
      end
      default: begin
        repeat (MAX_NEST) burst.push_back(CH_L);
        burst.push_back(CH_D);
      end
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    if (!calm && $urandom_range(0, 9) < tx_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b);
    sent++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_token(out_token_kind, out_number_value, out_string_byte, out_nest_depth,
                        out_in_key, out_end_of_string, out_value_done, out_error_code);
  end

  initial begin
    int hold_left;
    int stall_left;
    int rx_rate;
    int win;
    bit hold_taken;
    hold_left = 0;
    stall_left = 0;
    rx_rate = 0;
    win = 0;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (win == 0) begin
        win = 64;
        rx_rate = $urandom_range(0, 3);
      end
      win--;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) < rx_rate) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    int  cut;
    int  k;
    bit  held;
    bit  drained;
    held = 1'b0;
    drained = 1'b0;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst.push_back(8'h00);
    burst.push_back(8'hff);
    push_text("edld1:aei-0eiei1-l0:dei-12ee");
    send_burst();

    while (sent < 830) begin
      tx_rate = $urandom_range(0, 3);
      calm = (sent > 690);
      if (!held && sent >= 250) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && sent >= 500) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (board.tokens_due.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        7: begin
          while (!board.at_top()) send_byte(8'hff);
          gen_special();
        end
        8: begin
          gen_value(0);
          cut = $urandom_range(0, burst.size() - 1);
          while (burst.size() > cut) void'(burst.pop_back());
          burst.push_back(8'($urandom_range(0, 255)));
        end
        9: repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(0, 255)));
        default: begin
          while (!board.at_top()) send_byte(8'hff);
          gen_value(0);
        end
      endcase
      send_burst();
    end

    in_valid <= 1'b0;
    for (k = 0; k < 4000 && board.tokens_due.size() != 0; k++) @(posedge clk);
    if (board.tokens_due.size() != 0) begin
      $error("%0d expected tokens never arrived", board.tokens_due.size());
      board.errors++;
    end
    repeat (6) @(posedge clk);
    if (board.errors == 0) $display("bencode_stream_tokenizer_unit_tb: done, clean");
    else $display("bencode_stream_tokenizer_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("bencode_stream_tokenizer_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/bst_pkg.sv
design/bst_stack.sv
design/bencode_stream_tokenizer_unit.sv
tb/bencode_stream_tokenizer_unit_tb.sv
